/* src/fbg_pkg.sv */
// Shared types and constants of the framed bar graph renderer.
// No dependencies; imported by every module of the block but fbg_div.
`timescale 1ns / 1ps
`default_nettype none

package fbg_pkg;

   // Widths fixed by the register and field formats.
   localparam int WW    = 5;   // clamped bar width, at most 15 (field holds up to 31)
   localparam int MAGW  = 6;   // magnitude of a scaled span, up to 47
   localparam int NUMW  = 22;  // 16-bit value times a 6-bit span
   localparam int MAX_FRAME = 7;

   localparam int QDEPTH = 2;
   localparam int QPW    = 1;

   localparam logic [7:0] CMD_COL  = 8'h80;
   localparam logic [7:0] CMD_LINE = 8'h40;

   localparam logic [15:0] RST_MAX_VALUE      = 16'd100;
   localparam logic [3:0]  RST_BAR_WIDTH      = 4'd8;
   localparam logic [2:0]  RST_HEIGHT_BYTES   = 3'd4;
   localparam logic [2:0]  RST_OUTER_FRAME    = 3'd1;
   localparam logic [2:0]  RST_INNER_FRAME    = 3'd1;
   localparam logic [6:0]  RST_DISPLAY_WIDTH  = 7'd84;
   localparam logic [5:0]  RST_DISPLAY_HEIGHT = 6'd48;

   typedef enum logic [2:0] {
      CSR_MAX_VALUE      = 3'd0,
      CSR_BAR_WIDTH      = 3'd1,
      CSR_HEIGHT_BYTES   = 3'd2,
      CSR_OUTER_FRAME    = 3'd3,
      CSR_INNER_FRAME    = 3'd4,
      CSR_DISPLAY_WIDTH  = 3'd5,
      CSR_DISPLAY_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] max_value;
      logic [3:0]  bar_width;
      logic [2:0]  height_bytes;
      logic [2:0]  outer_frame;
      logic [2:0]  inner_frame;
      logic [6:0]  display_width;
      logic [5:0]  display_height;
   } cfg_type;

   // One classified request, ready for byte generation.
   typedef struct packed {
      logic [WW-1:0] w;       // clamped bar width
      logic [2:0]    h;       // clamped page rows
      logic [2:0]    o;
      logic [2:0]    g;
      logic [7:0]    top;     // first bar pixel row
      logic [7:0]    d0;      // first limit line pixel row
      logic [6:0]    cm0;     // start column mod display width
      logic [6:0]    cm_end;  // end column mod display width
      logic [7:0]    ypos;
      logic [2:0]    r0;      // start line mod line modulus
      logic [3:0]    lm;      // line modulus
   } desc_type;

endpackage

`default_nettype wire

/* src/framed_bar_graph_renderer_top.sv */
// Top level of the framed bar graph renderer: register file, front end,
// descriptor queue and byte sequencer. Uses fbg_pkg, fbg_front, fbg_queue, fbg_back.
`timescale 1ns / 1ps
`default_nettype none

// One request (value, limit, cursor) yields 2 + h*(w+2) bytes for an LCD with
// 8 pixels per byte: per page row a column and a line command and w pixel bytes,
// then a closing cursor pair whose line command is flagged with rsp_last. The byte
// sequencer sends one byte per cycle while rsp_stall is low, up to 62 bytes per
// request, and starts the next request's bytes right after the last one. The front
// end takes one request at a time: capture, multiply, the steps of the bit-serial
// dividers that scale value and limit, a done check, and a descriptor push into a
// two-entry queue that waits while it is full; req_stall is high until the push.
// Registers are to be written through csr_write/csr_index/csr_wdata only while no
// request is in flight; the block itself does not enforce this.
module framed_bar_graph_renderer_top import fbg_pkg::*; #(
   parameter int MAX_BAR_WIDTH    = 8,
   parameter int MAX_HEIGHT_BYTES = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_value,
   input  wire logic [15:0] req_limit,
   input  wire logic [7:0]  req_x_position,
   input  wire logic [7:0]  req_line_position,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_data,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_push, q_full, q_pop, q_empty;
   desc_type q_wr_data, q_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_VALUE:      cfg_in.max_value      = csr_wdata;
            CSR_BAR_WIDTH:      cfg_in.bar_width      = csr_wdata[3:0];
            CSR_HEIGHT_BYTES:   cfg_in.height_bytes   = csr_wdata[2:0];
            CSR_OUTER_FRAME:    cfg_in.outer_frame    = csr_wdata[2:0];
            CSR_INNER_FRAME:    cfg_in.inner_frame    = csr_wdata[2:0];
            CSR_DISPLAY_WIDTH:  cfg_in.display_width  = csr_wdata[6:0];
            CSR_DISPLAY_HEIGHT: cfg_in.display_height = csr_wdata[5:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_value      <= RST_MAX_VALUE;
         cfg_ff.bar_width      <= RST_BAR_WIDTH;
         cfg_ff.height_bytes   <= RST_HEIGHT_BYTES;
         cfg_ff.outer_frame    <= RST_OUTER_FRAME;
         cfg_ff.inner_frame    <= RST_INNER_FRAME;
         cfg_ff.display_width  <= RST_DISPLAY_WIDTH;
         cfg_ff.display_height <= RST_DISPLAY_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbg_front #(
      .MAX_BAR_WIDTH   (MAX_BAR_WIDTH),
      .MAX_HEIGHT_BYTES(MAX_HEIGHT_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_limit        (req_limit),
      .req_x_position   (req_x_position),
      .req_line_position(req_line_position),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_wr_data)
   );

   fbg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_data(q_wr_data),
      .full   (q_full),
      .pop    (q_pop),
      .rd_data(q_rd_data),
      .empty  (q_empty)
   );

   fbg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_rd_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_data (rsp_is_data),
      .rsp_last    (rsp_last)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("descriptor pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("descriptor popped from an empty queue");

   a_last_is_line_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_is_data && rsp_out_byte[7:6] == CMD_LINE[7:6])
      else $error("run does not end on a line command");

   a_rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_is_data) && $stable(rsp_last))
      else $error("stalled transfer changed");
`endif

endmodule

`default_nettype wire

/* src/fbg_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by fbg_front for scaling and cursor moduli.
`timescale 1ns / 1ps
`default_nettype none

module fbg_div #(
   parameter int NW = 8,
   parameter int DW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic [NW-1:0]      quot,
   output logic [DW-1:0]      rem
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fit;

   always_comb begin
      trial  = {rem_ff, quo_ff[NW-1]};
      diff   = trial - {1'b0, den_ff};
      fit    = (trial >= {1'b0, den_ff});
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CW'(NW);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         rem_in = fit ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = (cnt_ff != '0);
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

/* src/fbg_front.sv */
// Request front end: clamps, scales value and limit, reduces cursor positions.
// Uses fbg_pkg and fbg_div; pushes one descriptor per request to fbg_queue.
`timescale 1ns / 1ps
`default_nettype none

module fbg_front import fbg_pkg::*; #(
   parameter int MAX_BAR_WIDTH    = 8,
   parameter int MAX_HEIGHT_BYTES = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_value,
   input  wire logic [15:0] req_limit,
   input  wire logic [7:0]  req_x_position,
   input  wire logic [7:0]  req_line_position,
   input  wire logic        q_full,
   output logic             q_push,
   output desc_type         q_data
);

   // dh/9 for a 6-bit dh as a reciprocal multiply
   localparam int DIV9_MUL   = 57;
   localparam int DIV9_SHIFT = 9;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] limit_ff, limit_in;
   logic [7:0]  xpos_ff, xpos_in;
   logic [7:0]  ypos_ff, ypos_in;

   logic [WW-1:0]   w_c;
   logic [2:0]      h_c;
   logic [7:0]      hp8;
   logic signed [8:0] hp_s, o_s, g_s, dp_s, span_s, dp_abs, span_abs;
   logic            neg_p, neg_v;
   logic [15:0]     limc;
   logic [NUMW-1:0] num_p, num_v;
   logic [7:0]      xend;
   logic [3:0]      lm;
   logic            start;
   logic            busy_p, busy_v, busy_c0, busy_c1, busy_l;
   logic [NUMW-1:0] quot_p, quot_v;
   logic [6:0]      rem_c0, rem_c1, rem_l;
   logic [7:0]      qp8, qv8, plim, m8, pval;

   function automatic logic [3:0] line_modulus(input logic [5:0] dh);
      logic [11:0] p;
      p = 12'(dh) * 12'(DIV9_MUL);
      return 4'(p >> DIV9_SHIFT) + 4'd1;
   endfunction

   always_comb begin
      w_c = ({1'b0, cfg.bar_width} > WW'(MAX_BAR_WIDTH)) ? WW'(MAX_BAR_WIDTH)
                                                        : {1'b0, cfg.bar_width};
      h_c = (cfg.height_bytes > 3'(MAX_HEIGHT_BYTES)) ? 3'(MAX_HEIGHT_BYTES)
                                                      : cfg.height_bytes;
      hp8    = {2'b00, h_c, 3'b000};
      hp_s   = $signed({1'b0, hp8});
      o_s    = $signed({6'b0, cfg.outer_frame});
      g_s    = $signed({6'b0, cfg.inner_frame});
      dp_s   = hp_s - o_s - 9'sd5;
      span_s = hp_s - o_s - o_s - g_s - g_s - 9'sd1;
      neg_p  = dp_s[8];
      neg_v  = span_s[8];
      dp_abs   = neg_p ? -dp_s : dp_s;
      span_abs = neg_v ? -span_s : span_s;
      limc   = (limit_ff > cfg.max_value) ? cfg.max_value : limit_ff;
      num_p  = NUMW'(limc) * NUMW'(dp_abs[MAGW-1:0]);
      num_v  = NUMW'(value_ff) * NUMW'(span_abs[MAGW-1:0]);
      xend   = xpos_ff + 8'(w_c) + 8'd1;
      lm     = line_modulus(cfg.display_height);
   end

   assign start = (state_ff == F_MUL);

   fbg_div #(.NW(NUMW), .DW(16)) u_div_lim (
      .clock(clock), .reset(reset), .start(start), .num(num_p), .den(cfg.max_value),
      .busy(busy_p), .quot(quot_p), .rem()
   );

   fbg_div #(.NW(NUMW), .DW(16)) u_div_val (
      .clock(clock), .reset(reset), .start(start), .num(num_v), .den(cfg.max_value),
      .busy(busy_v), .quot(quot_v), .rem()
   );

   fbg_div #(.NW(8), .DW(7)) u_mod_col0 (
      .clock(clock), .reset(reset), .start(start), .num(xpos_ff),
      .den(cfg.display_width), .busy(busy_c0), .quot(), .rem(rem_c0)
   );

   fbg_div #(.NW(8), .DW(7)) u_mod_col1 (
      .clock(clock), .reset(reset), .start(start), .num(xend),
      .den(cfg.display_width), .busy(busy_c1), .quot(), .rem(rem_c1)
   );

   fbg_div #(.NW(8), .DW(7)) u_mod_line (
      .clock(clock), .reset(reset), .start(start), .num(ypos_ff),
      .den({3'b000, lm}), .busy(busy_l), .quot(), .rem(rem_l)
   );

   // Scaled results wrap at 8 bits, so only the low quotient byte matters.
   always_comb begin
      qp8  = (cfg.max_value == '0) ? 8'd0 : quot_p[7:0];
      qv8  = (cfg.max_value == '0) ? 8'd0 : quot_v[7:0];
      plim = (neg_p ? -qp8 : qp8) + 8'd2;
      m8   = neg_v ? -qv8 : qv8;
      pval = ($signed({1'b0, m8}) > span_s) ? span_s[7:0] : m8;

      q_data.w      = w_c;
      q_data.h      = h_c;
      q_data.o      = cfg.outer_frame;
      q_data.g      = cfg.inner_frame;
      q_data.top    = hp8 - pval - {5'b0, cfg.outer_frame} - {5'b0, cfg.inner_frame} - 8'd1;
      q_data.d0     = hp8 - plim - {5'b0, cfg.outer_frame} - 8'd1;
      q_data.cm0    = (cfg.display_width == '0) ? 7'd0 : rem_c0;
      q_data.cm_end = (cfg.display_width == '0) ? 7'd0 : rem_c1;
      q_data.ypos   = ypos_ff;
      q_data.r0     = rem_l[2:0];
      q_data.lm     = lm;
   end

   assign req_stall = (state_ff != F_IDLE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      limit_in = limit_ff;
      xpos_in  = xpos_ff;
      ypos_in  = ypos_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               limit_in = req_limit;
               xpos_in  = req_x_position;
               ypos_in  = req_line_position;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_DIV;
         end
         F_DIV: begin
            if (!(busy_p || busy_v || busy_c0 || busy_c1 || busy_l)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      limit_ff <= limit_in;
      xpos_ff  <= xpos_in;
      ypos_ff  <= ypos_in;
   end

endmodule

`default_nettype wire

/* src/fbg_queue.sv */
// Two-entry descriptor queue between the front end and the byte sequencer.
// Uses fbg_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module fbg_queue import fbg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type wr_data,
   output logic          full,
   input  wire logic     pop,
   output desc_type      rd_data,
   output logic          empty
);

   localparam int CNTW = $clog2(QDEPTH + 1);

   desc_type          entries_ff [QDEPTH];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNTW'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* src/fbg_back.sv */
// Byte sequencer: turns one descriptor into cursor and pixel bytes.
// Uses fbg_pkg; pops descriptors from fbg_queue, drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module fbg_back import fbg_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire desc_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_is_data,
   output logic          rsp_last
);

   typedef enum logic [5:0] {
      B_IDLE     = 6'b000001,
      B_COL      = 6'b000010,
      B_LINE     = 6'b000100,
      B_DATA     = 6'b001000,
      B_END_COL  = 6'b010000,
      B_END_LINE = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   desc_type       job_ff, job_in;
   logic [2:0]     y_ff, y_in;
   logic [WW-1:0]  x_ff, x_in;
   logic [7:0]     l_ff, l_in;
   logic [2:0]     r_ff, r_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           data_ff, data_in;
   logic           last_ff, last_in;

   logic           out_free;
   logic [7:0]     pix;
   logic [7:0]     barp;
   logic [7:0]     pat;
   logic [7:0]     d_i;
   logic [2:0]     nl;
   logic           in_bar;
   logic signed [6:0] xs, ws, os, gs;
   logic signed [4:0] s_s;
   logic [2:0]     sh;
   logic [7:0]     mask;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Pixel byte for column x_ff of page row y_ff.
   always_comb begin
      xs = $signed({2'b00, x_ff});
      ws = $signed({2'b00, job_ff.w});
      os = $signed({4'b0000, job_ff.o});
      gs = $signed({4'b0000, job_ff.g});
      if ({2'b00, y_ff} < job_ff.top[7:3]) begin
         barp = 8'h00;
      end else if ({2'b00, y_ff} > job_ff.top[7:3]) begin
         barp = 8'hff;
      end else begin
         barp = 8'hff << job_ff.top[2:0];
      end

      // limit line, one pixel row per outer frame pixel (at least one)
      nl  = (job_ff.o > 3'd1) ? job_ff.o : 3'd1;
      pat = 8'h00;
      d_i = 8'h00;
      for (int i = 0; i < MAX_FRAME; i++) begin
         d_i = job_ff.d0 + 8'(i);
         if ((3'(i) < nl) && (d_i[7:3] == {2'b00, y_ff})) begin
            pat[d_i[2:0]] = 1'b1;
         end
      end

      in_bar = 1'b0;
      if (xs < os) begin
         pix = 8'hff;
      end else if (xs < os + gs) begin
         pix = 8'h00;
      end else if (xs < ws - os - gs) begin
         pix    = barp;
         in_bar = 1'b1;
      end else if (xs < ws - os) begin
         pix = 8'h00;
      end else begin
         pix = 8'hff;
      end

      pix = pix ^ pat;
      if (y_ff == 3'd0) begin
         pix = pix | ((8'd1 << job_ff.o) - 8'd1);
      end
      s_s  = 5'sd7 - $signed({2'b00, job_ff.o}) - $signed({2'b00, job_ff.g});
      sh   = s_s[4] ? 3'd0 : s_s[2:0];
      mask = (8'hff << sh) & (8'hff >> ({1'b0, job_ff.o} + 4'd1));
      if (y_ff == job_ff.h - 3'd1) begin
         pix = pix | (8'hff << (3'd7 - job_ff.o));
         if (in_bar) begin
            pix = pix & ~mask;
         end
         pix = pix & 8'h7f;
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      data_in      = data_ff;
      last_in      = last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               y_in     = '0;
               x_in     = '0;
               l_in     = q_data.ypos;
               r_in     = q_data.r0;
               state_in = (q_data.h != '0) ? B_COL : B_END_COL;
            end
         end
         B_COL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = CMD_COL | {1'b0, job_ff.cm0};
               data_in      = 1'b0;
               last_in      = 1'b0;
               state_in     = B_LINE;
            end
         end
         B_LINE, B_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               if (state_ff == B_LINE) begin
                  byte_in = CMD_LINE | {5'b0, r_ff};
                  data_in = 1'b0;
                  x_in    = '0;
               end else begin
                  byte_in = pix;
                  data_in = 1'b1;
                  x_in    = x_ff + WW'(1);
               end
               if ((state_ff == B_LINE && job_ff.w != '0) ||
                   (state_ff == B_DATA && x_ff != job_ff.w - WW'(1))) begin
                  state_in = B_DATA;
               end else if (y_ff == job_ff.h - 3'd1) begin
                  state_in = B_END_COL;
               end else begin
                  // next page row; line wraps at 8 bits before the modulus
                  state_in = B_COL;
                  y_in     = y_ff + 3'd1;
                  if (l_ff == 8'hff) begin
                     l_in = 8'h00;
                     r_in = 3'd0;
                  end else begin
                     l_in = l_ff + 8'd1;
                     r_in = ({1'b0, r_ff} + 4'd1 == job_ff.lm) ? 3'd0 : r_ff + 3'd1;
                  end
               end
            end
         end
         B_END_COL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = CMD_COL | {1'b0, job_ff.cm_end};
               data_in      = 1'b0;
               last_in      = 1'b0;
               state_in     = B_END_LINE;
            end
         end
         B_END_LINE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = CMD_LINE | {5'b0, job_ff.r0};
               data_in      = 1'b0;
               last_in      = 1'b1;
               // pick up the next descriptor without a bubble
               if (!q_empty) begin
                  q_pop    = 1'b1;
                  job_in   = q_data;
                  y_in     = '0;
                  x_in     = '0;
                  l_in     = q_data.ypos;
                  r_in     = q_data.r0;
                  state_in = (q_data.h != '0) ? B_COL : B_END_COL;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff  <= job_in;
      y_ff    <= y_in;
      x_ff    <= x_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      byte_ff <= byte_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_data  = data_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire
